@@ src/soft_timer_bank_core_assert.svh @@
// Assertion macros for the soft timer bank core.
// Uses clk and rst_n of the including module; no other dependencies.
`ifndef SOFT_TIMER_BANK_CORE_ASSERT_SVH
`define SOFT_TIMER_BANK_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define STB_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define STB_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/stb_pkg.sv @@
// Shared types and constants for the soft timer bank.
// No dependencies.
package stb_pkg;

    localparam int MASK_W           = 6;
    localparam int REQ_W            = 3;
    localparam int CHAN_W           = 3;
    localparam int IVL_W            = 16;
    localparam int TICK_W           = 32;
    localparam int MOD_CHANNELS     = 3;
    localparam int DEF_NUM_CHANNELS = 6;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK    = 3'd0,
        REQ_START   = 3'd1,
        REQ_RESTART = 3'd2,
        REQ_STOP    = 3'd3,
        REQ_RESUME  = 3'd4
    } req_code_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMD,
        S_SCAN,
        S_MOD_WAIT,
        S_FINISH
    } stb_state_t;

    typedef struct packed {
        logic              start;
        logic [TICK_W-1:0] dividend;
        logic [IVL_W-1:0]  divisor;
    } mod_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic rem_zero;
    } mod_sts_t;

endpackage

@@ src/stb_if.sv @@
// Handshake channels of the soft timer bank: request and response.
// Depends on stb_pkg for field widths.
interface stb_req_if
    import stb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [CHAN_W-1:0] channel;
    logic [IVL_W-1:0]  interval;

    modport source (output valid, req_type, channel, interval, input ready);
    modport sink   (input valid, req_type, channel, interval, output ready);
endinterface

interface stb_rsp_if
    import stb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] fire_mask;
    logic [MASK_W-1:0] running_mask;

    modport source (output valid, fire_mask, running_mask, input ready);
    modport sink   (input valid, fire_mask, running_mask, output ready);
endinterface

@@ src/stb_mod_unit.sv @@
// Iterative remainder unit: one restoring step per cycle, 32 steps.
// Depends on stb_pkg for the control and status structs.
module stb_mod_unit
    import stb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mod_ctl_t ctl,
    output mod_sts_t sts
);
    localparam int CNT_W = $clog2(TICK_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TICK_W-1:0] dvd_reg, dvd_next;
    logic [IVL_W-1:0]  dvs_reg, dvs_next;
    logic [IVL_W-1:0]  rem_reg, rem_next;
    logic [IVL_W:0]    shifted;
    logic [IVL_W:0]    trial;

    assign shifted = {rem_reg, dvd_reg[TICK_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(TICK_W - 1);
            dvd_next  = ctl.dividend;
            dvs_next  = ctl.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // keep the partial remainder below the divisor
            rem_next = trial[IVL_W] ? shifted[IVL_W-1:0] : trial[IVL_W-1:0];
            dvd_next = {dvd_reg[TICK_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign sts.busy     = busy_reg;
    assign sts.done     = done_reg;
    assign sts.rem_zero = (rem_reg == '0);

endmodule

@@ src/soft_timer_bank_core.sv @@
// Soft timer bank top level: channel state, scan sequencer, response register.
// Depends on stb_pkg, stb_if, stb_mod_unit and soft_timer_bank_core_assert.svh.
//
// Usage:
//   req carries one transaction per item: a tick, or a start, restart, stop or
//   resume command for one channel. rsp returns exactly one transaction per
//   item with the fire mask (ticks only) and the running mask after the item.
// Sequencing:
//   A command passes through the command and finish steps to a loaded response.
//   A tick walks the channels one per cycle, except that each running modulo
//   channel with a nonzero interval holds the walk while it occupies the shared
//   remainder unit (start, 32 restoring steps, done).
//   req.ready is high only while no item is in flight.
// Reset:
//   Clears the tick count, all intervals and down counts, stops all channels
//   and empties the response register.
// Stall:
//   The response register frees when rsp is taken; the next item can be
//   accepted while a response still waits, but its own response holds in the
//   finish step until the register is free.
`include "soft_timer_bank_core_assert.svh"

module soft_timer_bank_core
    import stb_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
)
(
    input  logic      clk,
    input  logic      rst_n,
    stb_req_if.sink   req,
    stb_rsp_if.source rsp
);
    localparam int IDX_W = $clog2(NUM_CHANNELS);

    stb_state_t state_reg, state_next;

    // Channel state
    logic [TICK_W-1:0]       tick_count_reg, tick_count_next;
    logic [IVL_W-1:0]        period_reg [NUM_CHANNELS];
    logic [IVL_W-1:0]        period_next [NUM_CHANNELS];
    logic [IVL_W-1:0]        down_reg [NUM_CHANNELS];
    logic [IVL_W-1:0]        down_next [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] run_reg, run_next;

    // Item being worked on
    logic [REQ_W-1:0]  req_type_reg, req_type_next;
    logic [IVL_W-1:0]  ivl_reg, ivl_next;
    logic              cmd_ok_reg, cmd_ok_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [MASK_W-1:0] fire_reg, fire_next;

    // Response register
    logic              out_valid_reg, out_valid_next;
    logic [MASK_W-1:0] out_fire_reg, out_fire_next;
    logic [MASK_W-1:0] out_run_reg, out_run_next;

    mod_ctl_t mod_ctl;
    mod_sts_t mod_sts;

    logic             accept;
    logic             out_free;
    logic             cur_run;
    logic             cur_is_mod;
    logic [IVL_W-1:0] cur_period;
    logic [IVL_W-1:0] cur_down;
    logic             last_chan;
    logic             need_mod;

    assign accept     = req.valid && req.ready;
    assign out_free   = !out_valid_reg || rsp.ready;
    assign cur_run    = run_reg[idx_reg];
    assign cur_is_mod = int'(idx_reg) < MOD_CHANNELS;
    assign cur_period = period_reg[idx_reg];
    assign cur_down   = down_reg[idx_reg];
    assign last_chan  = (idx_reg == IDX_W'(NUM_CHANNELS - 1));
    // a modulo channel with a zero interval never fires: skip the unit
    assign need_mod   = cur_run && cur_is_mod && (cur_period != '0);

    stb_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mod_ctl),
        .sts   (mod_sts)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req.req_type == REQ_TICK) ? S_SCAN : S_CMD;
                end
            end
            S_CMD:
            begin
                state_next = S_FINISH;
            end
            S_SCAN:
            begin
                if (need_mod)
                begin
                    state_next = S_MOD_WAIT;
                end
                else if (last_chan)
                begin
                    state_next = S_FINISH;
                end
            end
            S_MOD_WAIT:
            begin
                if (mod_sts.done)
                begin
                    state_next = last_chan ? S_FINISH : S_SCAN;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        req.ready        = (state_reg == S_IDLE);
        rsp.valid        = out_valid_reg;
        rsp.fire_mask    = out_fire_reg;
        rsp.running_mask = out_run_reg;
        mod_ctl.start    = (state_reg == S_SCAN) && need_mod;
        mod_ctl.dividend = tick_count_reg;
        mod_ctl.divisor  = cur_period;
    end

    // Datapath
    always_comb
    begin
        tick_count_next = tick_count_reg;
        period_next     = period_reg;
        down_next       = down_reg;
        run_next        = run_reg;
        req_type_next   = req_type_reg;
        ivl_next        = ivl_reg;
        cmd_ok_next     = cmd_ok_reg;
        idx_next        = idx_reg;
        fire_next       = fire_reg;
        out_valid_next  = out_valid_reg;
        out_fire_next   = out_fire_reg;
        out_run_next    = out_run_reg;

        // drop the response once taken
        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_type_next = req.req_type;
                    ivl_next      = req.interval;
                    cmd_ok_next   = int'(req.channel) < NUM_CHANNELS;
                    fire_next     = '0;
                    if (req.req_type == REQ_TICK)
                    begin
                        // advance on every tick, wrapping at 2^32
                        tick_count_next = tick_count_reg + 1'b1;
                        idx_next        = '0;
                    end
                    else
                    begin
                        idx_next = req.channel[IDX_W-1:0];
                    end
                end
            end
            S_CMD:
            begin
                // out-of-range channels and unknown codes change nothing
                if (cmd_ok_reg)
                begin
                    case (req_type_reg)
                        REQ_START:
                        begin
                            period_next[idx_reg] = ivl_reg;
                            down_next[idx_reg]   = ivl_reg;
                            run_next[idx_reg]    = 1'b1;
                        end
                        REQ_RESTART:
                        begin
                            down_next[idx_reg] = cur_period;
                            run_next[idx_reg]  = 1'b1;
                        end
                        REQ_STOP:
                        begin
                            run_next[idx_reg] = 1'b0;
                        end
                        REQ_RESUME:
                        begin
                            run_next[idx_reg] = 1'b1;
                        end
                        default:
                        begin
                            run_next = run_reg;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // countdown channel: fire and reload at zero, else decrement
                if (cur_run && !cur_is_mod)
                begin
                    if (cur_down == '0)
                    begin
                        down_next[idx_reg] = cur_period;
                        fire_next          = fire_reg | (MASK_W'(1) << idx_reg);
                    end
                    else
                    begin
                        down_next[idx_reg] = cur_down - 1'b1;
                    end
                end
                if (!need_mod && !last_chan)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_MOD_WAIT:
            begin
                if (mod_sts.done)
                begin
                    if (mod_sts.rem_zero)
                    begin
                        fire_next = fire_reg | (MASK_W'(1) << idx_reg);
                    end
                    if (!last_chan)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_fire_next  = fire_reg;
                    out_run_next   = MASK_W'(run_reg);
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tick_count_reg <= '0;
            run_reg        <= '0;
            out_valid_reg  <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                period_reg[c] <= '0;
                down_reg[c]   <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            tick_count_reg <= tick_count_next;
            run_reg        <= run_next;
            out_valid_reg  <= out_valid_next;
            period_reg     <= period_next;
            down_reg       <= down_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_type_reg <= req_type_next;
        ivl_reg      <= ivl_next;
        cmd_ok_reg   <= cmd_ok_next;
        idx_reg      <= idx_next;
        fire_reg     <= fire_next;
        out_fire_reg <= out_fire_next;
        out_run_reg  <= out_run_next;
    end

    // A tick transaction advances the shared count by exactly one
    `STB_ASSERT_NXT(a_tick_adv, accept && (req.req_type == REQ_TICK), tick_count_reg == $past(tick_count_reg) + 1'b1, "tick count did not advance")
    // The remainder unit only runs while the sequencer waits for it
    `STB_ASSERT_NOW(a_mod_owner, mod_sts.busy, state_reg == S_MOD_WAIT, "remainder unit busy outside wait")
    // Commands never report a fire
    `STB_ASSERT_NOW(a_cmd_nofire, (state_reg == S_FINISH) && (req_type_reg != REQ_TICK), fire_reg == '0, "fire on command")
    // The scan never changes which channels run
    `STB_ASSERT_NXT(a_scan_run, state_reg == S_SCAN, $stable(run_reg), "run flags changed during scan")

endmodule

@@ verif/tb_soft_timer_bank_core.sv @@
// Testbench for soft_timer_bank_core: directed table, then constrained-free random traffic.
// Depends on stb_pkg, stb_if and the RTL of the timer bank; checks every response against
// its typed row masks or an in-bench model of tick count, intervals, countdowns, run flags.
`timescale 1ns / 1ps

module tb_soft_timer_bank_core
    import stb_pkg::*;
();

    localparam int NUM_CH       = 6;
    localparam int RANDOM_ITEMS = 1800;
    localparam int CALM_FIRST   = 700;     // random items in [CALM_FIRST, CALM_LAST) never idle
    localparam int CALM_LAST    = 1000;
    localparam int IDLE_PCT     = 12;
    localparam int DRAIN_CYCLES = 150;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DIR_N        = 25;

    // Request codes 5 to 7 have no meaning; the block must ignore them.
    localparam logic [REQ_W-1:0] REQ_RESERVED_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RESERVED_HI = 3'd7;

    typedef struct packed {
        logic [MASK_W-1:0] fire;
        logic [MASK_W-1:0] running;
    } timer_masks_t;

    // One directed row; when typed is set the masks are the literal expectation,
    // otherwise the model computes them.
    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [CHAN_W-1:0] chan;
        logic [IVL_W-1:0]  ivl;
        logic              typed;
        logic [MASK_W-1:0] fire;
        logic [MASK_W-1:0] running;
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [DIR_N] = '{
        // Nothing runs after reset: a tick fires nothing.
        '{REQ_TICK,        3'd0, 16'h0000, 1'b1, 6'h00, 6'h00},
        // Zero interval on a modulo channel never fires.
        '{REQ_START,       3'd0, 16'h0000, 1'b1, 6'h00, 6'h01},
        '{REQ_TICK,        3'd0, 16'h0000, 1'b1, 6'h00, 6'h01},
        // Zero interval on a countdown channel fires every tick.
        '{REQ_START,       3'd3, 16'h0000, 1'b1, 6'h00, 6'h09},
        '{REQ_TICK,        3'd5, 16'hFFFF, 1'b1, 6'h08, 6'h09},
        '{REQ_TICK,        3'd7, 16'h0000, 1'b1, 6'h08, 6'h09},
        // Largest intervals on both channel kinds, and the smallest nonzero one.
        '{REQ_START,       3'd1, 16'hFFFF, 1'b1, 6'h00, 6'h0B},
        '{REQ_START,       3'd5, 16'hFFFF, 1'b1, 6'h00, 6'h2B},
        '{REQ_START,       3'd2, 16'h0001, 1'b1, 6'h00, 6'h2F},
        '{REQ_TICK,        3'd0, 16'h0000, 1'b0, 6'h00, 6'h00},
        '{REQ_START,       3'd4, 16'h0002, 1'b0, 6'h00, 6'h00},
        '{REQ_TICK,        3'd0, 16'h0000, 1'b0, 6'h00, 6'h00},
        '{REQ_TICK,        3'd0, 16'h0000, 1'b0, 6'h00, 6'h00},
        '{REQ_TICK,        3'd0, 16'h0000, 1'b0, 6'h00, 6'h00},
        // Stop keeps the counts, resume picks them up again.
        '{REQ_STOP,        3'd3, 16'h0000, 1'b0, 6'h00, 6'h00},
        '{REQ_TICK,        3'd0, 16'h0000, 1'b0, 6'h00, 6'h00},
        '{REQ_RESUME,      3'd3, 16'h0000, 1'b0, 6'h00, 6'h00},
        '{REQ_RESTART,     3'd5, 16'h0000, 1'b0, 6'h00, 6'h00},
        '{REQ_TICK,        3'd0, 16'h0000, 1'b0, 6'h00, 6'h00},
        // Channels past the bank and reserved request codes change nothing.
        '{REQ_START,       3'd6, 16'hFFFF, 1'b0, 6'h00, 6'h00},
        '{REQ_STOP,        3'd7, 16'h0000, 1'b0, 6'h00, 6'h00},
        '{REQ_RESERVED_LO, 3'd0, 16'h1234, 1'b0, 6'h00, 6'h00},
        '{REQ_RESERVED_HI, 3'd7, 16'hFFFF, 1'b0, 6'h00, 6'h00},
        '{REQ_STOP,        3'd0, 16'h0000, 1'b0, 6'h00, 6'h00},
        '{REQ_TICK,        3'd0, 16'h0000, 1'b0, 6'h00, 6'h00}
    };

    logic clk;
    logic rst_n;

    stb_req_if req_ch ();
    stb_rsp_if rsp_ch ();

    soft_timer_bank_core #(
        .NUM_CHANNELS (NUM_CH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Model state: a private copy of the bank, updated once per accepted request.
    logic [TICK_W-1:0] tick_total = '0;
    logic [IVL_W-1:0]  period_q    [NUM_CH] = '{default: '0};
    logic [IVL_W-1:0]  countdown_q [NUM_CH] = '{default: '0};
    logic [NUM_CH-1:0] run_q = '0;

    timer_masks_t pending_masks [$];   // expected responses, oldest first
    int           mismatch_count = 0;
    int           cycle_count = 0;
    bit           calm = 1'b0;         // set while both sides must not idle

    // Advance the model by one request and return the masks it should report.
    function automatic timer_masks_t timer_bank_step(
        input logic [REQ_W-1:0]  kind,
        input logic [CHAN_W-1:0] chan,
        input logic [IVL_W-1:0]  ivl
    );
        timer_masks_t r;
        r.fire = '0;
        if (kind == REQ_TICK)
        begin
            // The shared count advances on every tick, even with all channels stopped.
            tick_total = tick_total + 1'b1;
            for (int c = 0; c < NUM_CH; c++)
            begin
                if (run_q[c])
                begin
                    if (c < MOD_CHANNELS)
                    begin
                        // Skip the modulo when the interval is zero: never fire.
                        if (period_q[c] != '0 && (tick_total % period_q[c]) == '0)
                            r.fire[c] = 1'b1;
                    end
                    else if (countdown_q[c] == '0)
                    begin
                        // Expire at zero and reload, so the period is interval + 1.
                        countdown_q[c] = period_q[c];
                        r.fire[c]      = 1'b1;
                    end
                    else
                    begin
                        countdown_q[c] = countdown_q[c] - 1'b1;
                    end
                end
            end
        end
        else if (chan < NUM_CH)
        begin
            case (kind)
                REQ_START:
                begin
                    period_q[chan]    = ivl;
                    countdown_q[chan] = ivl;
                    run_q[chan]       = 1'b1;
                end
                REQ_RESTART:
                begin
                    countdown_q[chan] = period_q[chan];
                    run_q[chan]       = 1'b1;
                end
                REQ_STOP:   run_q[chan] = 1'b0;
                REQ_RESUME: run_q[chan] = 1'b1;
                default: ;
            endcase
        end
        r.running = run_q;
        return r;
    endfunction

    // Offer one request transaction, hold it until accepted, then queue the
    // expected response. Valid only drops when an idle gap follows.
    task automatic send_request(
        input logic [REQ_W-1:0]  kind,
        input logic [CHAN_W-1:0] chan,
        input logic [IVL_W-1:0]  ivl,
        input logic              typed,
        input logic [MASK_W-1:0] fire,
        input logic [MASK_W-1:0] running
    );
        timer_masks_t predicted;
        if (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.channel  <= chan;
        req_ch.interval <= ivl;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        // Accepted at this edge: advance the model in step with the block.
        predicted = timer_bank_step(kind, chan, ivl);
        if (typed)
            pending_masks.push_back(timer_masks_t'{fire: fire, running: running});
        else
            pending_masks.push_back(predicted);
    endtask

    // Build one random request: mostly ticks and well-formed commands with
    // small intervals so channels actually expire; a few bad channels and codes.
    task automatic send_random_request();
        logic [REQ_W-1:0]  kind;
        logic [CHAN_W-1:0] chan;
        logic [IVL_W-1:0]  ivl;
        int                pick;
        int                ivl_pick;
        pick = $urandom_range(0, 99);
        chan = CHAN_W'($urandom_range(0, NUM_CH - 1));
        ivl  = IVL_W'($urandom);
        if (pick < 50)
        begin
            kind = REQ_TICK;
            chan = CHAN_W'($urandom_range(0, 7));
        end
        else if (pick < 65)
        begin
            kind     = REQ_START;
            ivl_pick = $urandom_range(0, 9);
            if (ivl_pick == 0)
                ivl = '0;
            else if (ivl_pick == 1)
                ivl = '1;
            else if (ivl_pick > 2)
                ivl = IVL_W'($urandom_range(1, 12));
        end
        else if (pick < 73)
            kind = REQ_RESTART;
        else if (pick < 83)
            kind = REQ_STOP;
        else if (pick < 93)
            kind = REQ_RESUME;
        else if (pick < 96)
        begin
            // Reserved code, any channel.
            kind = REQ_W'($urandom_range(REQ_RESERVED_LO, REQ_RESERVED_HI));
            chan = CHAN_W'($urandom_range(0, 7));
        end
        else
        begin
            // Valid command aimed past the last channel.
            kind = REQ_W'($urandom_range(REQ_START, REQ_RESUME));
            chan = CHAN_W'($urandom_range(NUM_CH, 7));
        end
        send_request(kind, chan, ivl, 1'b0, '0, '0);
    endtask

    // Free-running clock, 10 ns period.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: end the run if the traffic never drains.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Response side: compare each accepted transaction with the oldest
    // expectation, then pick the next ready at random (never low while calm).
    initial
    begin
        timer_masks_t want;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_masks.size() == 0)
                begin
                    $display("%0t: unexpected response: expected none, actual fire %h running %h",
                             $time, rsp_ch.fire_mask, rsp_ch.running_mask);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_masks.pop_front();
                    if (rsp_ch.fire_mask !== want.fire)
                    begin
                        $display("%0t: fire_mask mismatch: expected %h, actual %h",
                                 $time, want.fire, rsp_ch.fire_mask);
                        mismatch_count++;
                    end
                    if (rsp_ch.running_mask !== want.running)
                    begin
                        $display("%0t: running_mask mismatch: expected %h, actual %h",
                                 $time, want.running, rsp_ch.running_mask);
                        mismatch_count++;
                    end
                end
            end
            rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Request side: reset once, walk the directed table, then random traffic,
    // then drain and report.
    initial
    begin
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_TICK;
        req_ch.channel  <= '0;
        req_ch.interval <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
            send_request(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].chan, DIRECTED_ROWS[i].ivl,
                         DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].fire,
                         DIRECTED_ROWS[i].running);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= CALM_FIRST && n < CALM_LAST);
            send_random_request();
        end
        calm = 1'b0;

        // Drop valid at the last acceptance edge, then wait out the responses.
        req_ch.valid <= 1'b0;
        while (pending_masks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
